/* rtl/dgcc_pkg.sv */
`default_nettype none

package dgcc_pkg;

   // Function codes carried by req_func
   typedef enum logic [1:0] {
      FUNC_ADD   = 2'd0,
      FUNC_CHECK = 2'd1,
      FUNC_CLEAR = 2'd2
   } func_type;

   localparam int CSR_WIDTH       = 6;
   localparam int NODE_FIELD_BITS = 5;
   localparam logic [CSR_WIDTH-1:0] NUM_NODES_RESET = 6'd32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_ROOT,
      ST_LOAD,
      ST_SCAN,
      ST_POP,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic latch_req;
      logic clear_adj;
      logic add_write;
      logic check_init;
      logic root_skip;
      logic root_push;
      logic root_retire;
      logic cursor_step;
      logic node_push;
      logic node_pop;
      logic pop_load;
      logic row_load;
      logic cycle_found;
      logic rsp_load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic edge_ok;
      logic root_done;
      logic root_visited;
      logic cur_done;
      logic sp_zero;
      logic edge_hit;
      logic tgt_visited;
      logic tgt_on_path;
   } status_type;

endpackage

`default_nettype wire

/* rtl/directed_graph_cycle_check.sv */
`default_nettype none

// Directed graph cycle check. Transfer an item with req_func = add (0) to
// store the edge req_src -> req_dst, check (1) to run a depth-first search
// over nodes below the node count, or clear (2) to drop all edges; code 3 is
// ignored. Only a check returns a transfer on rsp_, with rsp_has_cycle set if
// any directed cycle (a self-loop included) exists among those nodes. The node
// count is written through csr_write_en / csr_write_data, which the user
// must do only while idle; the block itself does not enforce this. Values
// above MAX_NODES act as MAX_NODES, and edges touching a node at or above the
// count are ignored on add and skipped by a check. An add reads the adjacency
// row from RAM, merges in the new edge and writes it back. A check is paced
// by the neighbor scan, which tests one adjacency bit per cycle, plus one
// registered RAM read each time the search descends and two (stack entry,
// then row) each time it returns. Reset and clear empty the matrix at once
// through per-row valid flags, so no clearing pass is needed. A finished
// result sits in an output register, so the next item is taken while it
// waits.
module directed_graph_cycle_check #(
   parameter int MAX_NODES = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_func,
   input  wire logic [4:0] req_src,
   input  wire logic [4:0] req_dst,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_has_cycle,
   input  wire logic       csr_write_en,
   input  wire logic [5:0] csr_write_data
);

   import dgcc_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequence adds, clears and the search; own the result handshake
   dgcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // hold the adjacency RAM, path stack, search masks and node count
   dgcc_datapath #(
      .MAX_NODES (MAX_NODES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_src        (req_src),
      .req_dst        (req_dst),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .rsp_has_cycle  (rsp_has_cycle),
      .cmd            (cmd),
      .status         (status)
   );

endmodule

`default_nettype wire

/* rtl/dgcc_ram.sv */
`default_nettype none

module dgcc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/dgcc_ctrl.sv */
`default_nettype none

module dgcc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic [1:0]           req_func,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire dgcc_pkg::status_type status,
   output dgcc_pkg::cmd_type         cmd
);

   import dgcc_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_ADD:   if (status.edge_ok) state_in = ST_ADD_RD;
                  FUNC_CHECK: state_in = ST_ROOT;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD_RD: state_in = ST_ADD_WR;
         ST_ADD_WR: state_in = ST_IDLE;
         ST_ROOT: begin
            if (status.root_done) begin
               state_in = ST_DONE;
            end else if (!status.root_visited) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: state_in = ST_SCAN;
         ST_SCAN: begin
            if (status.cur_done) begin
               state_in = status.sp_zero ? ST_ROOT : ST_POP;
            end else if (status.edge_hit && !status.tgt_visited) begin
               state_in = ST_LOAD;
            end else if (status.edge_hit && status.tgt_on_path) begin
               state_in = ST_DONE;
            end
         end
         ST_POP: state_in = ST_LOAD;
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.latch_req = accept;
            if (accept) begin
               case (req_func)
                  FUNC_CHECK: cmd.check_init = 1'b1;
                  FUNC_CLEAR: cmd.clear_adj  = 1'b1;
                  default:    cmd.check_init = 1'b0;
               endcase
            end
         end
         ST_ADD_RD: cmd.add_write = 1'b0;
         ST_ADD_WR: cmd.add_write = 1'b1;
         ST_ROOT: begin
            if (!status.root_done) begin
               cmd.root_skip = status.root_visited;
               cmd.root_push = !status.root_visited;
            end
         end
         ST_LOAD: cmd.row_load = 1'b1;
         ST_SCAN: begin
            if (status.cur_done) begin
               cmd.root_retire = status.sp_zero;
               cmd.node_pop    = !status.sp_zero;
            end else if (status.edge_hit && !status.tgt_visited) begin
               cmd.node_push = 1'b1;
            end else if (status.edge_hit && status.tgt_on_path) begin
               cmd.cycle_found = 1'b1;
            end else begin
               cmd.cursor_step = 1'b1;
            end
         end
         ST_POP: cmd.pop_load = 1'b1;
         ST_DONE: cmd.rsp_load = !rsp_valid_ff || !rsp_stall;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // never overwrite a result that has not been taken
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten while stalled");

   assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == FUNC_CHECK) |=> (state_ff == ST_ROOT))
      else $error("check did not start the root scan");

endmodule

`default_nettype wire

/* rtl/dgcc_datapath.sv */
`default_nettype none

module dgcc_datapath #(
   parameter int MAX_NODES = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [4:0]           req_src,
   input  wire logic [4:0]           req_dst,
   input  wire logic                 csr_write_en,
   input  wire logic [5:0]           csr_write_data,
   output logic                      rsp_has_cycle,
   input  wire dgcc_pkg::cmd_type    cmd,
   output dgcc_pkg::status_type      status
);

   import dgcc_pkg::*;

   localparam int NW = $clog2(MAX_NODES);      // node index
   localparam int CW = $clog2(MAX_NODES + 1);  // count / cursor
   localparam int SW = NW + CW;                // stack entry: node, cursor
   localparam logic [6:0] MAX7 = 7'(MAX_NODES);
   localparam logic [MAX_NODES-1:0] ONE = MAX_NODES'(1);

   logic [CSR_WIDTH-1:0]       num_ff, num_in;
   logic [NODE_FIELD_BITS-1:0] src_ff, dst_ff;
   logic [MAX_NODES-1:0]       visited_ff, visited_in;
   logic [MAX_NODES-1:0]       on_path_ff, on_path_in;
   logic [MAX_NODES-1:0]       rv_ff, rv_in;
   logic [MAX_NODES-1:0]       row_ff, row_in;
   logic [CW-1:0]              root_ff, root_in;
   logic [CW-1:0]              c_ff, c_in;
   logic [NW-1:0]              u_ff, u_in;
   logic [NW-1:0]              sp_ff, sp_in;
   logic                       cyc_ff, cyc_in;
   logic                       rsp_has_cycle_ff;
   logic                       rd_valid_ff;

   logic [6:0]           eff7;
   logic [CW-1:0]        eff_n;
   logic [NW-1:0]        c_idx, root_idx, src_idx;
   logic [NW-1:0]        adj_raddr;
   logic [MAX_NODES-1:0] adj_rdata, adj_wdata;
   logic [SW-1:0]        stk_rdata;
   logic [NW-1:0]        stk_node;

   // effective node count, capped at MAX_NODES
   assign eff7  = ({1'b0, num_ff} > MAX7) ? MAX7 : {1'b0, num_ff};
   assign eff_n = eff7[CW-1:0];

   assign c_idx    = c_ff[NW-1:0];
   assign root_idx = root_ff[NW-1:0];
   assign src_idx  = NW'(src_ff);
   assign stk_node = stk_rdata[SW-1:CW];

   assign status.edge_ok      = ({2'b00, req_src} < eff7) && ({2'b00, req_dst} < eff7);
   assign status.root_done    = (root_ff >= eff_n);
   assign status.root_visited = visited_ff[root_idx];
   assign status.cur_done     = (c_ff >= eff_n);
   assign status.sp_zero      = (sp_ff == '0);
   assign status.edge_hit     = row_ff[c_idx];
   assign status.tgt_visited  = visited_ff[c_idx];
   assign status.tgt_on_path  = on_path_ff[c_idx];

   assign rsp_has_cycle = rsp_has_cycle_ff;

   always_comb begin
      if (cmd.root_push) begin
         adj_raddr = root_idx;
      end else if (cmd.node_push) begin
         adj_raddr = c_idx;
      end else if (cmd.pop_load) begin
         adj_raddr = stk_node;
      end else begin
         adj_raddr = src_idx;
      end
   end

   assign adj_wdata = (rd_valid_ff ? adj_rdata : '0) | (ONE << dst_ff);

   dgcc_ram #(
      .WIDTH (MAX_NODES),
      .DEPTH (MAX_NODES)
   ) u_adj_ram (
      .clock   (clock),
      .wr_en   (cmd.add_write),
      .wr_addr (src_idx),
      .wr_data (adj_wdata),
      .rd_addr (adj_raddr),
      .rd_data (adj_rdata)
   );

   dgcc_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_NODES)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (cmd.node_push),
      .wr_addr (sp_ff),
      .wr_data ({u_ff, c_ff + 1'b1}),
      .rd_addr (sp_ff - 1'b1),
      .rd_data (stk_rdata)
   );

   always_comb begin
      num_in     = csr_write_en ? csr_write_data : num_ff;
      visited_in = visited_ff;
      on_path_in = on_path_ff;
      rv_in      = rv_ff;
      row_in     = row_ff;
      root_in    = root_ff;
      c_in       = c_ff;
      u_in       = u_ff;
      sp_in      = sp_ff;
      cyc_in     = cyc_ff;

      if (cmd.clear_adj) rv_in = '0;
      if (cmd.add_write) rv_in = rv_ff | (ONE << src_idx);

      if (cmd.check_init) begin
         visited_in = '0;
         on_path_in = '0;
         sp_in      = '0;
         root_in    = '0;
         cyc_in     = 1'b0;
      end
      if (cmd.root_skip) root_in = root_ff + 1'b1;
      if (cmd.root_push) begin
         u_in       = root_idx;
         c_in       = '0;
         visited_in = visited_ff | (ONE << root_idx);
         on_path_in = on_path_ff | (ONE << root_idx);
      end
      if (cmd.cursor_step) c_in = c_ff + 1'b1;
      if (cmd.node_push) begin
         sp_in      = sp_ff + 1'b1;
         u_in       = c_idx;
         c_in       = '0;
         visited_in = visited_ff | (ONE << c_idx);
         on_path_in = on_path_ff | (ONE << c_idx);
      end
      if (cmd.root_retire) begin
         on_path_in = on_path_ff & ~(ONE << u_ff);
         root_in    = root_ff + 1'b1;
      end
      if (cmd.node_pop) begin
         on_path_in = on_path_ff & ~(ONE << u_ff);
         sp_in      = sp_ff - 1'b1;
      end
      if (cmd.pop_load) begin
         u_in = stk_node;
         c_in = stk_rdata[CW-1:0];
      end
      if (cmd.row_load) row_in = rd_valid_ff ? adj_rdata : '0;
      if (cmd.cycle_found) cyc_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff     <= NUM_NODES_RESET;
         visited_ff <= '0;
         on_path_ff <= '0;
         rv_ff      <= '0;
         root_ff    <= '0;
         sp_ff      <= '0;
         cyc_ff     <= 1'b0;
      end else begin
         num_ff     <= num_in;
         visited_ff <= visited_in;
         on_path_ff <= on_path_in;
         rv_ff      <= rv_in;
         root_ff    <= root_in;
         sp_ff      <= sp_in;
         cyc_ff     <= cyc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         src_ff <= req_src;
         dst_ff <= req_dst;
      end
      if (cmd.rsp_load) rsp_has_cycle_ff <= cyc_ff;
      row_ff      <= row_in;
      c_ff        <= c_in;
      u_ff        <= u_in;
      rd_valid_ff <= rv_ff[adj_raddr];
   end

   // a node on the current path has always been visited
   assert property (@(posedge clock) disable iff (reset)
      (on_path_ff & ~visited_ff) == '0)
      else $error("path node not marked visited");

   // the ancestor stack never needs more than MAX_NODES-1 entries
   assert property (@(posedge clock) disable iff (reset)
      cmd.node_push |-> (sp_ff < NW'(MAX_NODES - 1)))
      else $error("ancestor stack overflow");

   assert property (@(posedge clock) disable iff (reset)
      cmd.clear_adj |=> (rv_ff == '0))
      else $error("clear left a row marked valid");

endmodule

`default_nettype wire
